// ===== rtl/core/ucs_pkg.sv =====
// Shared types, character codes and helper functions for the URL component splitter.
package ucs_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW = 2;
    localparam int MAX_RECS = 4;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    localparam logic [2:0] SEEN_PROTOCOL = 3'b001;
    localparam logic [2:0] SEEN_PORT = 3'b010;
    localparam logic [2:0] SEEN_PATH = 3'b100;

    typedef enum logic [2:0] {
        PH_NONE  = 3'd0,
        PH_HOST  = 3'd1,
        PH_PORT  = 3'd2,
        PH_PATH  = 3'd3,
        PH_QUERY = 3'd4,
        PH_FRAG  = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        KIND_PROTOCOL = 3'd0,
        KIND_HOST     = 3'd1,
        KIND_PORT     = 3'd2,
        KIND_PATH     = 3'd3,
        KIND_QUERY    = 3'd4,
        KIND_FRAGMENT = 3'd5
    } kind_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_url;
    } item_t;

    typedef struct packed {
        logic [2:0]  field_kind;
        logic [10:0] field_start;
        logic [11:0] field_length;
        logic        defaulted;
        logic        bad_url;
        logic        run_last;
    } field_t;

    typedef struct packed {
        logic [2:0]              count;
        field_t [MAX_RECS-1:0]   recs;
    } entry_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } q_stat_t;

    function automatic kind_t kind_of_phase(phase_t ph);
        kind_t k;
        begin
            case (ph)
                PH_HOST:  k = KIND_HOST;
                PH_PORT:  k = KIND_PORT;
                PH_PATH:  k = KIND_PATH;
                PH_QUERY: k = KIND_QUERY;
                PH_FRAG:  k = KIND_FRAGMENT;
                default:  k = KIND_HOST;
            endcase
            return k;
        end
    endfunction

    function automatic field_t default_rec(kind_t kind);
        field_t r;
        begin
            r = '0;
            r.field_kind = kind;
            r.defaulted = 1'b1;
            return r;
        end
    endfunction

endpackage

// ===== rtl/core/ucs_front.sv =====
// Front part: takes URL characters, tracks the parse phase and builds each item's record group.
module ucs_front #(
    parameter int MAX_URL_LEN = 2048
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  ucs_pkg::item_t   item_data,
    output logic             push,
    output ucs_pkg::entry_t  entry
);

    localparam int PW = $clog2(MAX_URL_LEN + 1);
    localparam logic [PW-1:0] MAX_POS = PW'(MAX_URL_LEN);
    localparam logic [PW-1:0] ONE = PW'(1);

    function automatic ucs_pkg::field_t close_rec(ucs_pkg::kind_t kind,
                                                 logic [PW-1:0] start,
                                                 logic [PW-1:0] stop);
        ucs_pkg::field_t r;
        begin
            r = '0;
            r.field_kind = kind;
            r.field_start = 11'(start);
            r.field_length = (stop >= start) ? 12'(stop - start) : 12'd0;
            return r;
        end
    endfunction

    ucs_pkg::phase_t phase_reg, phase_next;
    logic            colon_reg, colon_next;
    logic            skip_reg, skip_next;
    logic [PW-1:0]   seg_reg, seg_next;
    logic [PW-1:0]   pos_reg, pos_next;
    logic [2:0]      seen_reg, seen_next;
    logic            err_reg, err_next;

    ucs_pkg::field_t [ucs_pkg::MAX_RECS-1:0] recs_v;
    logic [2:0]      n_v;
    logic            letter_v;

    always_comb
    begin
        phase_next = phase_reg;
        colon_next = colon_reg;
        skip_next = skip_reg;
        seg_next = seg_reg;
        pos_next = pos_reg;
        seen_next = seen_reg;
        err_next = err_reg;
        recs_v = '0;
        n_v = 3'd0;
        letter_v = (item_data.ch inside {[ucs_pkg::CH_UPPER_A:ucs_pkg::CH_UPPER_Z],
                                         [ucs_pkg::CH_LOWER_A:ucs_pkg::CH_LOWER_Z]});

        if (item_data.end_of_url)
        begin
            if (colon_reg)
            begin
                err_next = 1'b1;
                if (phase_reg == ucs_pkg::PH_NONE)
                begin
                    recs_v[n_v[1:0]] = close_rec(ucs_pkg::KIND_HOST, seg_next, pos_reg - ONE);
                    n_v = n_v + 3'd1;
                    phase_next = ucs_pkg::PH_PORT;
                    seen_next = seen_next | ucs_pkg::SEEN_PORT;
                    seg_next = pos_reg;
                end
            end
            recs_v[n_v[1:0]] = close_rec(ucs_pkg::kind_of_phase(phase_next), seg_next, pos_reg);
            n_v = n_v + 3'd1;
            if ((seen_next & ucs_pkg::SEEN_PROTOCOL) == 3'd0)
            begin
                recs_v[n_v[1:0]] = ucs_pkg::default_rec(ucs_pkg::KIND_PROTOCOL);
                n_v = n_v + 3'd1;
            end
            if ((seen_next & ucs_pkg::SEEN_PORT) == 3'd0)
            begin
                recs_v[n_v[1:0]] = ucs_pkg::default_rec(ucs_pkg::KIND_PORT);
                n_v = n_v + 3'd1;
            end
            if ((seen_next & ucs_pkg::SEEN_PATH) == 3'd0)
            begin
                recs_v[n_v[1:0]] = ucs_pkg::default_rec(ucs_pkg::KIND_PATH);
                n_v = n_v + 3'd1;
            end
        end
        else if (pos_reg >= MAX_POS)
        begin
            err_next = 1'b1;
        end
        else
        begin
            pos_next = pos_reg + ONE;
            colon_next = (item_data.ch == ucs_pkg::CH_COLON);
            if (colon_reg && letter_v)
            begin
                err_next = 1'b1;
            end
            if (skip_reg)
            begin
                skip_next = 1'b0;
                seg_next = pos_reg + ONE;
            end
            else if (colon_reg && phase_reg == ucs_pkg::PH_NONE
                     && item_data.ch == ucs_pkg::CH_SLASH)
            begin
                recs_v[n_v[1:0]] = close_rec(ucs_pkg::KIND_PROTOCOL, seg_reg, pos_reg - ONE);
                n_v = n_v + 3'd1;
                seen_next = seen_next | ucs_pkg::SEEN_PROTOCOL;
                phase_next = ucs_pkg::PH_HOST;
                skip_next = 1'b1;
                seg_next = pos_reg + ONE;
            end
            else
            begin
                if (colon_reg && phase_reg == ucs_pkg::PH_NONE)
                begin
                    recs_v[n_v[1:0]] = close_rec(ucs_pkg::KIND_HOST, seg_reg, pos_reg - ONE);
                    n_v = n_v + 3'd1;
                    phase_next = ucs_pkg::PH_PORT;
                    seen_next = seen_next | ucs_pkg::SEEN_PORT;
                    seg_next = pos_reg;
                end
                if (item_data.ch == ucs_pkg::CH_COLON && phase_next == ucs_pkg::PH_HOST)
                begin
                    recs_v[n_v[1:0]] = close_rec(ucs_pkg::kind_of_phase(phase_next),
                                                 seg_next, pos_reg);
                    n_v = n_v + 3'd1;
                    phase_next = ucs_pkg::PH_PORT;
                    seen_next = seen_next | ucs_pkg::SEEN_PORT;
                    seg_next = pos_reg + ONE;
                end
                else if (item_data.ch == ucs_pkg::CH_SLASH && phase_next <= ucs_pkg::PH_PORT)
                begin
                    recs_v[n_v[1:0]] = close_rec(ucs_pkg::kind_of_phase(phase_next),
                                                 seg_next, pos_reg);
                    n_v = n_v + 3'd1;
                    phase_next = ucs_pkg::PH_PATH;
                    seen_next = seen_next | ucs_pkg::SEEN_PATH;
                    seg_next = pos_reg;
                end
                else if (item_data.ch == ucs_pkg::CH_QUEST && phase_next <= ucs_pkg::PH_PATH)
                begin
                    recs_v[n_v[1:0]] = close_rec(ucs_pkg::kind_of_phase(phase_next),
                                                 seg_next, pos_reg);
                    n_v = n_v + 3'd1;
                    phase_next = ucs_pkg::PH_QUERY;
                    seg_next = pos_reg + ONE;
                end
                else if (item_data.ch == ucs_pkg::CH_HASH && phase_next <= ucs_pkg::PH_QUERY)
                begin
                    recs_v[n_v[1:0]] = close_rec(ucs_pkg::kind_of_phase(phase_next),
                                                 seg_next, pos_reg);
                    n_v = n_v + 3'd1;
                    phase_next = ucs_pkg::PH_FRAG;
                    seg_next = pos_reg + ONE;
                end
            end
        end

        for (int i = 0; i < ucs_pkg::MAX_RECS; i++)
        begin
            recs_v[i].bad_url = err_next;
            recs_v[i].run_last = ((3'(i) + 3'd1) == n_v);
        end
    end

    assign entry.count = n_v;
    assign entry.recs = recs_v;
    assign push = accept && (n_v != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ucs_pkg::PH_NONE;
            colon_reg <= 1'b0;
            skip_reg <= 1'b0;
            seg_reg <= '0;
            pos_reg <= '0;
            seen_reg <= 3'd0;
            err_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (item_data.end_of_url)
            begin
                phase_reg <= ucs_pkg::PH_NONE;
                colon_reg <= 1'b0;
                skip_reg <= 1'b0;
                seg_reg <= '0;
                pos_reg <= '0;
                seen_reg <= 3'd0;
                err_reg <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                colon_reg <= colon_next;
                skip_reg <= skip_next;
                seg_reg <= seg_next;
                pos_reg <= pos_next;
                seen_reg <= seen_next;
                err_reg <= err_next;
            end
        end
    end

endmodule

// ===== rtl/core/ucs_queue.sv =====
// Short queue of record groups between the front and back parts.
module ucs_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ucs_pkg::entry_t   push_entry,
    input  logic              pop,
    output ucs_pkg::entry_t   head,
    output ucs_pkg::q_stat_t  stat
);

    localparam logic [ucs_pkg::QAW-1:0] PTR_STEP = (ucs_pkg::QAW)'(1);
    localparam logic [ucs_pkg::QAW:0]   CNT_STEP = (ucs_pkg::QAW + 1)'(1);

    ucs_pkg::entry_t mem_reg [ucs_pkg::QDEPTH];
    logic [ucs_pkg::QAW-1:0] wr_ptr_reg;
    logic [ucs_pkg::QAW-1:0] rd_ptr_reg;
    logic [ucs_pkg::QAW:0]   count_reg;
    logic                    do_push;
    logic                    do_pop;

    assign stat.not_empty = (count_reg != '0);
    assign stat.full = (count_reg == (ucs_pkg::QAW + 1)'(ucs_pkg::QDEPTH));
    assign do_push = push && !stat.full;
    assign do_pop = pop && stat.not_empty;
    assign head = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_STEP;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_STEP;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_STEP;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_STEP;
            end
        end
    end

endmodule

// ===== rtl/core/ucs_back.sv =====
// Back part: walks the records of the queue head and presents them one per word.
module ucs_back (
    input  logic              clk,
    input  logic              rst_n,
    input  ucs_pkg::entry_t   head,
    input  ucs_pkg::q_stat_t  stat,
    output logic              pop,
    output logic              field_valid,
    input  logic              field_stall,
    output ucs_pkg::field_t   field_data
);

    logic [1:0]      idx_reg, idx_next;
    logic            valid_reg, valid_next;
    ucs_pkg::field_t data_reg;
    logic            load;
    logic            last_rec;

    assign load = stat.not_empty && (!valid_reg || !field_stall);
    assign last_rec = ((3'(idx_reg) + 3'd1) == head.count);
    assign pop = load && last_rec;

    always_comb
    begin
        idx_next = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next = last_rec ? 2'd0 : idx_reg + 2'd1;
        end
        else if (!field_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= head.recs[idx_reg];
        end
    end

    assign field_valid = valid_reg;
    assign field_data = data_reg;

endmodule

// ===== rtl/core/url_component_splitter.sv =====
// Top level of the URL component splitter: front classifier, record queue and output sequencer.
// Usage: the input channel (item_valid, item_stall, item_data) takes one URL character per
// word; a word with end_of_url set closes the URL. The output channel (field_valid,
// field_stall, field_data) gives one field record per word: kind, start, length, defaulted
// flag, bad flag and run_last on the final record caused by one input word.
// Throughput: one input word per cycle while the queue is not full. A character that closes
// a field yields one or two records, an end word up to four; the output register moves one
// record per cycle while the receiver does not stall. The first record of an input word is
// written into the queue and then loaded into the output register.
// A four-entry queue of record groups sits between the front and the back; item_stall is high
// while that queue is full, so characters that cause no record wait only in that case.
// When the receiver stalls, the output word holds and the queue fills behind it.
// Reset clears the parse state, the queue and the output valid flag; no records are pending.
// Records of a URL whose end word carries bad_url are to be discarded by the receiver.
module url_component_splitter #(
    parameter int MAX_URL_LEN = 2048
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  ucs_pkg::item_t  item_data,
    output logic            field_valid,
    input  logic            field_stall,
    output ucs_pkg::field_t field_data
);

    logic             accept;
    logic             q_push;
    logic             q_pop;
    ucs_pkg::entry_t  q_in;
    ucs_pkg::entry_t  q_head;
    ucs_pkg::q_stat_t q_stat;

    assign item_stall = q_stat.full;
    assign accept = item_valid && !item_stall;

    ucs_front #(
        .MAX_URL_LEN(MAX_URL_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item_data (item_data),
        .push      (q_push),
        .entry     (q_in)
    );

    ucs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .head       (q_head),
        .stat       (q_stat)
    );

    ucs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .stat        (q_stat),
        .pop         (q_pop),
        .field_valid (field_valid),
        .field_stall (field_stall),
        .field_data  (field_data)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_stat.full))
        else $error("record group pushed into a full queue");

    a_end_gives_records: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item_data.end_of_url) |=> q_stat.not_empty)
        else $error("end word left no pending records");

    a_default_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (field_valid && field_data.defaulted) |->
        (field_data.field_start == 11'd0 && field_data.field_length == 12'd0))
        else $error("defaulted record carries a position");

    a_pop_only_with_data: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_stat.not_empty)
        else $error("queue popped while empty");

endmodule

// ===== dv/url_split_checker.sv =====
// Checker for the URL component splitter: watches both channels, predicts records, compares.
module url_split_checker
    import ucs_pkg::*;
#(
    parameter int URL_LIMIT = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_stall,
    input  item_t       item_data,
    input  logic        field_valid,
    input  logic        field_stall,
    input  field_t      field_data,
    output int          mismatches,
    output int          records_due,
    output int          records_checked
);

    phase_t      cur_phase;
    logic        colon_seen;
    logic        skip_slash;
    int unsigned field_begin;
    int unsigned char_count;
    logic [2:0]  present;
    logic        url_bad;

    field_t      step_out[$];
    field_t      fields_due[$];

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
    endfunction

    function automatic field_t make_field(kind_t kind, int unsigned start, int unsigned len,
                                          logic dflt);
        field_t f;
        f = '0;
        f.field_kind = kind;
        f.field_start = start[10:0];
        f.field_length = len[11:0];
        f.defaulted = dflt;
        return f;
    endfunction

    task automatic clear_parse();
        cur_phase = PH_NONE;
        colon_seen = 1'b0;
        skip_slash = 1'b0;
        field_begin = 0;
        char_count = 0;
        present = '0;
        url_bad = 1'b0;
    endtask

    // The open field ends just before offset stop; with no field open it counts as the host.
    task automatic close_open(int unsigned stop);
        int unsigned len;
        kind_t kind;
        len = (stop >= field_begin) ? stop - field_begin : 0;
        kind = (cur_phase == PH_NONE) ? KIND_HOST : kind_t'(cur_phase);
        step_out.push_back(make_field(kind, field_begin, len, 1'b0));
    endtask

    task automatic finish_step();
        foreach (step_out[i])
        begin
            step_out[i].bad_url = url_bad;
            step_out[i].run_last = (i == step_out.size() - 1);
            fields_due.push_back(step_out[i]);
        end
        step_out.delete();
    endtask

    task automatic split_word(input item_t w);
        int unsigned p;
        logic was_colon;
        logic handled;
        step_out.delete();
        if (w.end_of_url)
        begin
            if (colon_seen)
            begin
                url_bad = 1'b1;
                if (cur_phase == PH_NONE)
                begin
                    close_open(char_count - 1);
                    cur_phase = PH_PORT;
                    present |= SEEN_PORT;
                    field_begin = char_count;
                end
            end
            close_open(char_count);
            if ((present & SEEN_PROTOCOL) == '0)
                step_out.push_back(make_field(KIND_PROTOCOL, 0, 0, 1'b1));
            if ((present & SEEN_PORT) == '0)
                step_out.push_back(make_field(KIND_PORT, 0, 0, 1'b1));
            if ((present & SEEN_PATH) == '0)
                step_out.push_back(make_field(KIND_PATH, 0, 0, 1'b1));
            finish_step();
            clear_parse();
        end
        else if (char_count >= URL_LIMIT)
        begin
            url_bad = 1'b1;
        end
        else
        begin
            p = char_count;
            was_colon = colon_seen;
            char_count = p + 1;
            colon_seen = (w.ch == CH_COLON);
            if (was_colon && is_alpha(w.ch))
                url_bad = 1'b1;
            if (skip_slash)
            begin
                skip_slash = 1'b0;
                field_begin = p + 1;
            end
            else
            begin
                handled = 1'b0;
                // A colon with no field open is settled by the character after it.
                if (was_colon && cur_phase == PH_NONE)
                begin
                    if (w.ch == CH_SLASH)
                    begin
                        step_out.push_back(make_field(KIND_PROTOCOL, field_begin,
                                                      p - 1 - field_begin, 1'b0));
                        present |= SEEN_PROTOCOL;
                        cur_phase = PH_HOST;
                        skip_slash = 1'b1;
                        field_begin = p + 1;
                        handled = 1'b1;
                    end
                    else
                    begin
                        close_open(p - 1);
                        cur_phase = PH_PORT;
                        present |= SEEN_PORT;
                        field_begin = p;
                    end
                end
                if (!handled)
                begin
                    if (w.ch == CH_COLON && cur_phase == PH_HOST)
                    begin
                        close_open(p);
                        cur_phase = PH_PORT;
                        present |= SEEN_PORT;
                        field_begin = p + 1;
                    end
                    else if (w.ch == CH_SLASH && cur_phase <= PH_PORT)
                    begin
                        close_open(p);
                        cur_phase = PH_PATH;
                        present |= SEEN_PATH;
                        field_begin = p;
                    end
                    else if (w.ch == CH_QUEST && cur_phase <= PH_PATH)
                    begin
                        close_open(p);
                        cur_phase = PH_QUERY;
                        field_begin = p + 1;
                    end
                    else if (w.ch == CH_HASH && cur_phase <= PH_QUERY)
                    begin
                        close_open(p);
                        cur_phase = PH_FRAG;
                        field_begin = p + 1;
                    end
                end
            end
            finish_step();
        end
    endtask

    task automatic check_one(string name, logic [11:0] want, logic [11:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic compare_field(input field_t got);
        field_t want;
        records_checked++;
        if (fields_due.size() == 0)
        begin
            $error("record with nothing expected: kind %0d start %0d length %0d",
                   got.field_kind, got.field_start, got.field_length);
            mismatches++;
        end
        else
        begin
            want = fields_due.pop_front();
            check_one("field_kind", want.field_kind, got.field_kind);
            check_one("field_start", want.field_start, got.field_start);
            check_one("field_length", want.field_length, got.field_length);
            check_one("defaulted", want.defaulted, got.defaulted);
            check_one("bad_url", want.bad_url, got.bad_url);
            check_one("run_last", want.run_last, got.run_last);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parse();
            fields_due.delete();
            records_due = 0;
            mismatches = 0;
            records_checked = 0;
        end
        else
        begin
            if (field_valid && !field_stall)
                compare_field(field_data);
            if (item_valid && !item_stall)
                split_word(item_data);
            records_due = fields_due.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
// Top of the URL component splitter testbench: clock, reset, stimulus, stalls and verdict.
module testbench;
    import ucs_pkg::*;

    localparam int URL_LIMIT = 2048;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int RANDOM_WORDS = 280;

    localparam int FL_ALPHA = 0;
    localparam int FL_PLAIN = 1;
    localparam int FL_DIGIT = 2;
    localparam int FL_RICH = 3;
    localparam int FL_NOISE = 4;

    logic   clk;
    logic   rst_n = 1'b0;
    logic   item_valid = 1'b0;
    logic   item_stall;
    item_t  item_data = '0;
    logic   field_valid;
    logic   field_stall = 1'b0;
    field_t field_data;

    int     mismatches;
    int     records_due;
    int     records_checked;
    int     cycles = 0;
    int     words_sent = 0;
    logic   tx_calm = 1'b0;
    logic   rx_calm = 1'b0;
    int     rx_hold = 0;
    logic   took_field = 1'b0;
    logic [7:0] url_text[$];

    url_component_splitter #(
        .MAX_URL_LEN(URL_LIMIT)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item_data(item_data),
        .field_valid(field_valid),
        .field_stall(field_stall),
        .field_data(field_data)
    );

    url_split_checker #(
        .URL_LIMIT(URL_LIMIT)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item_data(item_data),
        .field_valid(field_valid),
        .field_stall(field_stall),
        .field_data(field_data),
        .mismatches(mismatches),
        .records_due(records_due),
        .records_checked(records_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        took_field <= field_valid && !field_stall;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // The receiver holds off for a drawn number of cycles after each word it takes.
    always @(negedge clk)
    begin
        if (took_field)
        begin
            if ($urandom_range(0, 9) == 0)
                rx_calm = !rx_calm;
            rx_hold = rx_calm ? 0 : $urandom_range(0, 16);
        end
        if (rx_hold > 0)
        begin
            field_stall <= 1'b1;
            rx_hold--;
        end
        else
        begin
            field_stall <= 1'b0;
        end
    end

    function automatic logic [7:0] pick_char(int flavor);
        string extra;
        string delim;
        extra = ".-_%~=&";
        delim = ":/?#";
        case (flavor)
            FL_ALPHA:
                return ($urandom_range(0, 1) == 0) ? 8'(CH_LOWER_A + $urandom_range(0, 25))
                                                   : 8'(CH_UPPER_A + $urandom_range(0, 25));
            FL_DIGIT:
                return 8'(8'h30 + $urandom_range(0, 9));
            FL_PLAIN:
                case ($urandom_range(0, 3))
                    0: return pick_char(FL_ALPHA);
                    1: return pick_char(FL_DIGIT);
                    2: return extra[$urandom_range(0, extra.len() - 1)];
                    default: return pick_char(FL_ALPHA);
                endcase
            FL_RICH:
                return ($urandom_range(0, 3) == 0) ? delim[$urandom_range(0, 3)]
                                                   : pick_char(FL_PLAIN);
            default:
                return ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
                                                   : pick_char(FL_RICH);
        endcase
    endfunction

    task automatic add_run(int count, int flavor);
        repeat (count)
            url_text.push_back(pick_char(flavor));
    endtask

    task automatic add_string(string s);
        for (int i = 0; i < s.len(); i++)
            url_text.push_back(s[i]);
    endtask

    task automatic build_well_formed();
        if ($urandom_range(0, 2) != 0)
        begin
            add_run($urandom_range(1, 5), FL_ALPHA);
            add_string("://");
        end
        add_run($urandom_range(0, 8), FL_PLAIN);
        if ($urandom_range(0, 1) == 0)
        begin
            url_text.push_back(CH_COLON);
            add_run($urandom_range(0, 5), FL_DIGIT);
        end
        if ($urandom_range(0, 2) != 0)
        begin
            url_text.push_back(CH_SLASH);
            add_run($urandom_range(0, 10), FL_RICH);
        end
        if ($urandom_range(0, 1) == 0)
        begin
            url_text.push_back(CH_QUEST);
            add_run($urandom_range(0, 8), FL_RICH);
        end
        if ($urandom_range(0, 2) == 0)
        begin
            url_text.push_back(CH_HASH);
            add_run($urandom_range(0, 8), FL_RICH);
        end
    endtask

    task automatic send_word(input logic [7:0] c, input logic eou);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 16);
        repeat (gap)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
        end
        @(negedge clk);
        item_valid <= 1'b1;
        item_data <= '{ch: c, end_of_url: eou};
        do
            @(posedge clk);
        while (item_stall);
        words_sent++;
    endtask

    // Sends the characters collected so far followed by the closing word.
    task automatic send_url(input logic calm);
        tx_calm = calm || ($urandom_range(0, 3) == 0);
        foreach (url_text[i])
            send_word(url_text[i], 1'b0);
        send_word(8'($urandom_range(0, 255)), 1'b1);
        url_text.delete();
    endtask

    initial
    begin
        int urls;
        int noise_urls;
        int random_start;
        urls = 0;
        noise_urls = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty URL, end during the skipped slash, colon at the end, all field kinds.
        send_url(1'b0);
        add_string("a:/");
        send_url(1'b0);
        add_string("h:");
        send_url(1'b0);
        add_string("a://h:9/?#:z");
        send_url(1'b0);
        url_text.push_back(8'h00);
        url_text.push_back(CH_COLON);
        url_text.push_back(8'hFF);
        send_url(1'b0);
        urls += 5;

        random_start = words_sent;
        while (words_sent - random_start < RANDOM_WORDS)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                add_run($urandom_range(0, 12), FL_NOISE);
                noise_urls++;
            end
            else
            begin
                build_well_formed();
            end
            send_url(1'b0);
            urls++;
        end

        @(negedge clk);
        item_valid <= 1'b0;
        while (records_due != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("Sent %0d words in %0d URLs, %0d of them random noise.",
                 words_sent, urls, noise_urls);
        $display("Compared %0d field records against the prediction.", records_checked);
        if (mismatches == 0 && records_due == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
